// ===== rtl/core/jsu_pkg.sv =====
`timescale 1ns / 1ps

package jsu_pkg;

  // decoder phase
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_STR     = 4'd1,
    PH_ESC     = 4'd2,
    PH_HEX_HI  = 4'd3,
    PH_WANT_BS = 4'd4,
    PH_WANT_U  = 4'd5,
    PH_HEX_LO  = 4'd6
  } phase_t;

  // result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NO_QUOTE  = 3'd1;
  localparam logic [2:0] ERR_UNTERM    = 3'd2;
  localparam logic [2:0] ERR_BAD_ESC   = 3'd3;
  localparam logic [2:0] ERR_BAD_HEX   = 3'd4;
  localparam logic [2:0] ERR_BAD_SURR  = 3'd5;
  localparam logic [2:0] ERR_LONE_SURR = 3'd6;
  localparam logic [2:0] ERR_CTRL_CHAR = 3'd7;

  localparam int MAX_RES = 4;

  // one result beat, without the last flag
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [2:0] code;
  } res_t;

  // decoder state
  typedef struct packed {
    phase_t      phase;
    logic [15:0] acc;
    logic [1:0]  digits;
    logic [9:0]  high_bits;
  } state_t;

  // decoder outcome for one input beat
  typedef struct packed {
    state_t                 st;
    logic [2:0]             count;
    res_t [MAX_RES-1:0]     res;
  } dec_t;

  function automatic res_t mk_res(input logic [1:0] kind, input logic [7:0] data,
                                  input logic [2:0] code);
    res_t r;
    r.kind = kind;
    r.data = data;
    r.code = code;
    return r;
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) v = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) v = {1'b1, 4'(c - 8'h37)};
    return v;
  endfunction

endpackage

// ===== rtl/core/jsu_decode.sv =====
`timescale 1ns / 1ps

module jsu_decode (
  input  jsu_pkg::state_t st,
  input  logic [7:0]      text_byte,
  input  logic            end_of_text,
  output jsu_pkg::dec_t   dec
);
  import jsu_pkg::*;

  logic [4:0]  hv;
  logic [15:0] acc_sh;
  logic [20:0] cp;
  logic        do_enc;
  logic        do_fail;
  logic [2:0]  fail_code;

  assign hv     = hex_val(text_byte);
  assign acc_sh = {st.acc[11:0], hv[3:0]};

  always_comb begin
    dec       = '0;
    dec.st    = st;
    cp        = 21'd0;
    do_enc    = 1'b0;
    do_fail   = 1'b0;
    fail_code = ERR_NONE;

    case (st.phase)
      PH_STR: begin
        if (end_of_text) begin
          do_fail   = 1'b1;
          fail_code = ERR_UNTERM;
        end else if (text_byte == 8'h22) begin
          dec.st.phase = PH_IDLE;
          dec.count    = 3'd1;
          dec.res[0]   = mk_res(KIND_CLOSE, 8'h00, ERR_NONE);
        end else if (text_byte == 8'h5c) begin
          dec.st.phase = PH_ESC;
        end else if (text_byte < 8'h20) begin
          do_fail   = 1'b1;
          fail_code = ERR_CTRL_CHAR;
        end else begin
          dec.count  = 3'd1;
          dec.res[0] = mk_res(KIND_DATA, text_byte, ERR_NONE);
        end
      end

      PH_ESC: begin
        dec.st.phase = PH_STR;
        dec.count    = 3'd1;
        if (end_of_text) begin
          do_fail   = 1'b1;
          fail_code = ERR_BAD_ESC;
        end else begin
          case (text_byte)
            8'h22: dec.res[0] = mk_res(KIND_DATA, 8'h22, ERR_NONE);
            8'h5c: dec.res[0] = mk_res(KIND_DATA, 8'h5c, ERR_NONE);
            8'h2f: dec.res[0] = mk_res(KIND_DATA, 8'h2f, ERR_NONE);
            8'h62: dec.res[0] = mk_res(KIND_DATA, 8'h08, ERR_NONE);
            8'h66: dec.res[0] = mk_res(KIND_DATA, 8'h0c, ERR_NONE);
            8'h6e: dec.res[0] = mk_res(KIND_DATA, 8'h0a, ERR_NONE);
            8'h72: dec.res[0] = mk_res(KIND_DATA, 8'h0d, ERR_NONE);
            8'h74: dec.res[0] = mk_res(KIND_DATA, 8'h09, ERR_NONE);
            8'h75: begin
              dec.st.phase  = PH_HEX_HI;
              dec.st.acc    = 16'd0;
              dec.st.digits = 2'd0;
              dec.count     = 3'd0;
            end
            default: begin
              do_fail   = 1'b1;
              fail_code = ERR_BAD_ESC;
            end
          endcase
        end
      end

      PH_HEX_HI: begin
        if (end_of_text || !hv[4]) begin
          do_fail   = 1'b1;
          fail_code = ERR_BAD_HEX;
        end else begin
          dec.st.acc = acc_sh;
          if (st.digits == 2'd3) begin
            dec.st.digits = 2'd0;
            if (acc_sh >= 16'hd800 && acc_sh <= 16'hdbff) begin
              dec.st.high_bits = acc_sh[9:0];
              dec.st.phase     = PH_WANT_BS;
            end else begin
              dec.st.phase = PH_STR;
              do_enc       = 1'b1;
              cp           = {5'd0, acc_sh};
            end
          end else begin
            dec.st.digits = st.digits + 2'd1;
          end
        end
      end

      PH_WANT_BS: begin
        if (end_of_text || text_byte != 8'h5c) begin
          do_fail   = 1'b1;
          fail_code = ERR_LONE_SURR;
        end else begin
          dec.st.phase = PH_WANT_U;
        end
      end

      PH_WANT_U: begin
        if (end_of_text || text_byte != 8'h75) begin
          do_fail   = 1'b1;
          fail_code = ERR_LONE_SURR;
        end else begin
          dec.st.phase  = PH_HEX_LO;
          dec.st.acc    = 16'd0;
          dec.st.digits = 2'd0;
        end
      end

      PH_HEX_LO: begin
        if (end_of_text || !hv[4]) begin
          do_fail   = 1'b1;
          fail_code = ERR_BAD_HEX;
        end else begin
          dec.st.acc = acc_sh;
          if (st.digits == 2'd3) begin
            dec.st.digits = 2'd0;
            if (acc_sh < 16'hdc00 || acc_sh > 16'hdfff) begin
              do_fail   = 1'b1;
              fail_code = ERR_BAD_SURR;
            end else begin
              // joined pair: 0x10000 plus ten high and ten low bits
              dec.st.phase = PH_STR;
              do_enc       = 1'b1;
              cp           = 21'h10000 + {1'b0, st.high_bits, acc_sh[9:0]};
            end
          end else begin
            dec.st.digits = st.digits + 2'd1;
          end
        end
      end

      default: begin
        if (end_of_text || text_byte != 8'h22) begin
          do_fail   = 1'b1;
          fail_code = ERR_NO_QUOTE;
        end else begin
          dec.st.phase     = PH_STR;
          dec.st.acc       = 16'd0;
          dec.st.digits    = 2'd0;
          dec.st.high_bits = 10'd0;
        end
      end
    endcase

    // utf-8 encode of a finished code point
    if (do_enc) begin
      if (cp < 21'h80) begin
        dec.count  = 3'd1;
        dec.res[0] = mk_res(KIND_DATA, cp[7:0], ERR_NONE);
      end else if (cp < 21'h800) begin
        dec.count  = 3'd2;
        dec.res[0] = mk_res(KIND_DATA, {3'b110, cp[10:6]}, ERR_NONE);
        dec.res[1] = mk_res(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE);
      end else if (cp < 21'h10000) begin
        dec.count  = 3'd3;
        dec.res[0] = mk_res(KIND_DATA, {4'b1110, cp[15:12]}, ERR_NONE);
        dec.res[1] = mk_res(KIND_DATA, {2'b10, cp[11:6]}, ERR_NONE);
        dec.res[2] = mk_res(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE);
      end else begin
        dec.count  = 3'd4;
        dec.res[0] = mk_res(KIND_DATA, {5'b11110, cp[20:18]}, ERR_NONE);
        dec.res[1] = mk_res(KIND_DATA, {2'b10, cp[17:12]}, ERR_NONE);
        dec.res[2] = mk_res(KIND_DATA, {2'b10, cp[11:6]}, ERR_NONE);
        dec.res[3] = mk_res(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE);
      end
    end

    // any error drops back to waiting with the hex state cleared
    if (do_fail) begin
      dec.st       = '0;
      dec.st.phase = PH_IDLE;
      dec.count    = 3'd1;
      dec.res      = '0;
      dec.res[0]   = mk_res(KIND_ERROR, 8'h00, fail_code);
    end
  end

endmodule

// ===== rtl/core/json_string_unescape_utf8_top.sv =====
`timescale 1ns / 1ps

// JSON string literal decoder. Feed the raw bytes of a string starting at its
// opening quote, one byte per input beat (or an end_of_text beat); the block
// emits the decoded UTF-8 bytes, a "string closed" beat at the closing quote,
// or a single error beat with its code, after which it waits for a new
// opening quote. Each input beat is decoded in the cycle it is accepted and
// its 0 to 4 result beats are loaded into a small result register that drains
// one beat per cycle while out_ready is high; out_last_of_run marks the
// final beat of each input. An input beat is taken every cycle while the
// result register is empty or its last pending beat leaves in that cycle;
// an input that produces several results holds the input side until all
// but its last result have left, as the output port carries one beat.
module json_string_unescape_utf8_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_result_kind,
  output logic [7:0] out_byte,
  output logic [2:0] out_error_code,
  output logic       out_last_of_run
);
  import jsu_pkg::*;

  state_t             st_r;
  dec_t               dec;
  res_t [MAX_RES-1:0] res_r;
  res_t [MAX_RES-1:0] res_nxt;
  logic [2:0]         rem_r;
  logic [2:0]         rem_nxt;
  logic               in_beat;
  logic               out_beat;

  jsu_decode u_decode (
    .st          (st_r),
    .text_byte   (in_text_byte),
    .end_of_text (in_end_of_text),
    .dec         (dec)
  );

  assign out_valid = (rem_r != 3'd0);
  assign out_beat  = out_valid && out_ready;
  assign in_ready  = (rem_r == 3'd0) || ((rem_r == 3'd1) && out_ready);
  assign in_beat   = in_valid && in_ready;

  assign out_result_kind = res_r[0].kind;
  assign out_byte        = res_r[0].data;
  assign out_error_code  = res_r[0].code;
  assign out_last_of_run = (rem_r == 3'd1);

  // load a fresh run or shift the pending one down by a beat
  always_comb begin
    res_nxt = res_r;
    rem_nxt = rem_r;
    if (in_beat && dec.count != 3'd0) begin
      res_nxt = dec.res;
      rem_nxt = dec.count;
    end else if (out_beat) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        res_nxt[i] = res_r[i+1];
      end
      rem_nxt = rem_r - 3'd1;
    end else if (in_beat) begin
      rem_nxt = 3'd0;
    end
  end

  // decoder state and result count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '{phase: PH_IDLE, acc: 16'd0, digits: 2'd0, high_bits: 10'd0};
      rem_r <= 3'd0;
    end else begin
      if (in_beat) st_r <= dec.st;
      rem_r <= rem_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule
